### src/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the sorted key search block.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition in one cycle that forces a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### src/tts_pkg.sv
// ============================================================================
// tts_pkg
// Types and constants shared by the two-table sorted key search block.
// ============================================================================
package tts_pkg;

    // Operation codes carried in the request.
    typedef enum logic [1:0] {
        FUNC_WR_MEMBER   = 2'd0,
        FUNC_WR_BONE     = 2'd1,
        FUNC_SRCH_MEMBER = 2'd2,
        FUNC_SRCH_BONE   = 2'd3
    } func_t;

    // Table select codes.
    localparam logic TBL_MEMBER = 1'b0;
    localparam logic TBL_BONE   = 1'b1;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMBER_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BONE_COUNT   = 1'b1;

    localparam int MEMBER_CNT_W = 5;
    localparam int BONE_CNT_W   = 7;
    localparam int KEY_W        = 32;
    localparam int SLOT_W       = 6;
    localparam int HIT_IDX_W    = 6;

    typedef struct packed {
        func_t             func;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
        logic              search_other;
    } req_t;

    typedef struct packed {
        logic                 found;
        logic                 hit_table;
        logic [HIT_IDX_W-1:0] hit_index;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_PROBE,
        ST_FINISH
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic write;    // store the request key in its table
        logic capture;  // latch a search request
        logic init;     // open a search window on the current table
        logic step;     // apply one probe comparison
        logic swap;     // move on to the other table
        logic load;     // move the search outcome into the response register
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic empty;      // current table has no valid entries
        logic hit;        // probed entry equals the key
        logic more;       // search window still open after this probe
        logic second_ok;  // the other table may still be searched
    } sts_t;

endpackage

### src/two_table_sorted_key_search_core.sv
// ============================================================================
// two_table_sorted_key_search_core
// Binary search over two software-loaded sorted key tables.
// ============================================================================
// The block holds a member table and a bone table of 32-bit keys, each loaded
// by write requests in ascending unsigned order, with the number of valid
// entries of each set through the configuration port. A write request produces
// no response. A search request binary-searches one table, and on a miss, if
// asked, the other one, then posts one response with found, the matching
// table and the position. The search probes one entry per clock through the
// registered read port of the table memory; a table of n valid entries needs
// at most floor(log2(n)) + 1 probes (5 for 16 entries, 7 for 64), and an
// empty table is skipped without a probe. One request is worked on at a time,
// but a new request is taken while the previous response still waits in the
// output register. Tables power up undefined and must be written before they
// are searched; counts reset to zero.
// ============================================================================
module two_table_sorted_key_search_core
    import tts_pkg::*;
#(
    parameter int MEMBER_DEPTH = 16,
    parameter int BONE_DEPTH   = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp
);

    // Commands from the sequencer and status back from the search datapath.
    cmd_t cmd;
    sts_t sts;

    // The sequencer owns the handshakes and steps the search one probe a cycle.
    tts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_func  (req.func),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the tables, the counts, the search window and the
    // response register.
    tts_dp #(
        .MEMBER_DEPTH (MEMBER_DEPTH),
        .BONE_DEPTH   (BONE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp)
    );

endmodule

### src/tts_ram.sv
// ============================================================================
// tts_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module tts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    assign rdata = rd_reg;

endmodule

### src/tts_ctrl.sv
// ============================================================================
// tts_ctrl
// Sequencer for write and search requests of the sorted key search block.
// ============================================================================
`include "assert_macros.svh"

module tts_ctrl
    import tts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  func_t req_func,
    output logic  rsp_valid,
    input  logic  rsp_ready,
    input  sts_t  sts,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   is_search;

    assign is_search = (req_func == FUNC_SRCH_MEMBER) || (req_func == FUNC_SRCH_BONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (is_search)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_START;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_START:
            begin
                cmd.init = 1'b1;
                if (sts.empty)
                begin
                    if (sts.second_ok)
                    begin
                        cmd.swap = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                cmd.step = 1'b1;
                if (sts.hit)
                begin
                    state_next = ST_FINISH;
                end
                else if (!sts.more)
                begin
                    if (sts.second_ok)
                    begin
                        cmd.swap   = 1'b1;
                        state_next = ST_START;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    `ASSERT_NEXT(a_search_starts, clk, rst_n, req_valid && req_ready && is_search,
        state_reg == ST_START, "accepted search did not open a table search")
    `ASSERT_NEXT(a_result_delivered, clk, rst_n,
        (state_reg == ST_FINISH) && (!rsp_valid_reg || rsp_ready),
        rsp_valid_reg && (state_reg == ST_IDLE), "finished search did not post its response")
    `ASSERT_PROP(a_no_overwrite, clk, rst_n, !cmd.load || !rsp_valid_reg || rsp_ready,
        "pending response overwritten")

endmodule

### src/tts_dp.sv
// ============================================================================
// tts_dp
// Key tables, count registers and the binary search window of the block.
// ============================================================================
`include "assert_macros.svh"

module tts_dp
    import tts_pkg::*;
#(
    parameter int MEMBER_DEPTH = 16,
    parameter int BONE_DEPTH   = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  req_t                  req,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    output rsp_t                  rsp
);

    localparam int MAW = (MEMBER_DEPTH > 1) ? $clog2(MEMBER_DEPTH) : 1;
    localparam int BAW = (BONE_DEPTH > 1) ? $clog2(BONE_DEPTH) : 1;
    localparam int MSW = $clog2(MEMBER_DEPTH + 1);
    localparam int BSW = $clog2(BONE_DEPTH + 1);
    localparam int TSW = (MSW > BSW) ? MSW : BSW;
    // Window width: holds either depth and either count register.
    localparam int SW  = (TSW > BONE_CNT_W) ? TSW : BONE_CNT_W;

    logic [MEMBER_CNT_W-1:0] member_count_reg;
    logic [BONE_CNT_W-1:0]   bone_count_reg;

    logic [KEY_W-1:0]     key_reg;
    logic                 cur_table_reg;
    logic                 other_reg;
    logic                 second_reg;
    logic [SW-1:0]        low_reg;
    logic [SW-1:0]        high_reg;
    logic [SW-1:0]        mid_reg;
    logic [SW-1:0]        mid_next;
    logic                 found_reg;
    logic                 hit_table_reg;
    logic [HIT_IDX_W-1:0] hit_index_reg;
    rsp_t                 rsp_reg;

    logic [SW-1:0]    m_cnt, b_cnt, m_bound, b_bound, bound;
    logic [KEY_W-1:0] m_rdata, b_rdata, entry;
    logic             key_lt, key_eq;
    logic [SW-1:0]    mid_inc, mid_lt, mid_gt;
    logic [SW:0]      sum_lt, sum_gt;
    logic             more_lt, more_gt;
    logic [SW-1:0]    step_low, step_high, step_mid;
    logic             m_we, b_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_count_reg <= '0;
            bone_count_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MEMBER_COUNT: member_count_reg <= cfg_data[MEMBER_CNT_W-1:0];
                CFG_BONE_COUNT:   bone_count_reg   <= cfg_data[BONE_CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // A count above the table depth searches the whole table.
    assign m_cnt   = SW'(member_count_reg);
    assign b_cnt   = SW'(bone_count_reg);
    assign m_bound = (m_cnt > SW'(MEMBER_DEPTH)) ? SW'(MEMBER_DEPTH) : m_cnt;
    assign b_bound = (b_cnt > SW'(BONE_DEPTH)) ? SW'(BONE_DEPTH) : b_cnt;
    assign bound   = (cur_table_reg == TBL_BONE) ? b_bound : m_bound;

    assign entry  = (cur_table_reg == TBL_BONE) ? b_rdata : m_rdata;
    assign key_lt = key_reg < entry;
    assign key_eq = key_reg == entry;

    // Both possible next probes are formed ahead of the compare.
    assign mid_inc = mid_reg + SW'(1);
    assign sum_lt  = {1'b0, low_reg} + {1'b0, mid_reg};
    assign sum_gt  = {1'b0, mid_inc} + {1'b0, high_reg};
    assign mid_lt  = sum_lt[SW:1];
    assign mid_gt  = sum_gt[SW:1];
    assign more_lt = low_reg < mid_reg;
    assign more_gt = mid_inc < high_reg;

    assign step_low  = key_lt ? low_reg : mid_inc;
    assign step_high = key_lt ? mid_reg : high_reg;
    assign step_mid  = key_lt ? mid_lt  : mid_gt;

    always_comb
    begin
        if (cmd.init)
        begin
            mid_next = {1'b0, bound[SW-1:1]};
        end
        else if (cmd.step)
        begin
            mid_next = step_mid;
        end
        else
        begin
            mid_next = mid_reg;
        end
    end

    assign sts.empty     = (bound == '0);
    assign sts.hit       = key_eq;
    assign sts.more      = key_lt ? more_lt : more_gt;
    assign sts.second_ok = other_reg && !second_reg;

    always_ff @(posedge clk)
    begin
        mid_reg <= mid_next;
        if (cmd.capture)
        begin
            key_reg       <= req.key;
            cur_table_reg <= (req.func == FUNC_SRCH_BONE) ? TBL_BONE : TBL_MEMBER;
            other_reg     <= req.search_other;
            second_reg    <= 1'b0;
            found_reg     <= 1'b0;
            hit_table_reg <= TBL_MEMBER;
            hit_index_reg <= '0;
        end
        if (cmd.init)
        begin
            low_reg  <= '0;
            high_reg <= bound;
        end
        if (cmd.step)
        begin
            low_reg  <= step_low;
            high_reg <= step_high;
            if (key_eq)
            begin
                found_reg     <= 1'b1;
                hit_table_reg <= cur_table_reg;
                hit_index_reg <= mid_reg[HIT_IDX_W-1:0];
            end
        end
        if (cmd.swap)
        begin
            cur_table_reg <= !cur_table_reg;
            second_reg    <= 1'b1;
        end
        if (cmd.load)
        begin
            rsp_reg.found     <= found_reg;
            rsp_reg.hit_table <= hit_table_reg;
            rsp_reg.hit_index <= hit_index_reg;
        end
    end

    assign rsp = rsp_reg;

    // Writes beyond the table depth are dropped.
    assign m_we = cmd.write && (req.func == FUNC_WR_MEMBER) && (int'(req.slot) < MEMBER_DEPTH);
    assign b_we = cmd.write && (req.func == FUNC_WR_BONE) && (int'(req.slot) < BONE_DEPTH);

    tts_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MEMBER_DEPTH)
    ) u_member_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (MAW'(req.slot)),
        .wdata (req.key),
        .raddr (mid_next[MAW-1:0]),
        .rdata (m_rdata)
    );

    tts_ram #(
        .WIDTH (KEY_W),
        .DEPTH (BONE_DEPTH)
    ) u_bone_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (BAW'(req.slot)),
        .wdata (req.key),
        .raddr (mid_next[BAW-1:0]),
        .rdata (b_rdata)
    );

    `ASSERT_PROP(a_probe_window_open, clk, rst_n, !cmd.step || (low_reg < high_reg),
        "probe issued on an empty search window")
    `ASSERT_PROP(a_probe_in_window, clk, rst_n,
        !cmd.step || ((mid_reg >= low_reg) && (mid_reg < high_reg)),
        "probe position outside the search window")

endmodule
